>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/iqr_pkg.sv
`timescale 1ns / 1ps
package iqr_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_BITS    = $clog2(MAX_SAMPLES);
    localparam int CNT_BITS    = 11;
    localparam int SUM_BITS    = SAMPLE_BITS + IDX_BITS + 1;
    localparam int NUM_BITS    = SUM_BITS + 8;
    localparam int MEAN_BITS   = 24;
    localparam int FENCE_BITS  = 8;
    localparam int FV_BITS     = SAMPLE_BITS + 4 + FENCE_BITS + 3;

    // Register indexes on the configuration port.
    localparam int REG_FENCE = 0;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
    } t_in_item;

    typedef struct packed {
        logic [MEAN_BITS-1:0]   mean_q8;
        logic [CNT_BITS-1:0]    kept_count;
        logic [SAMPLE_BITS-1:0] lower_quartile;
        logic [SAMPLE_BITS-1:0] upper_quartile;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic q1_load;
        logic q3_load;
        logic fences;
        logic scan;
        logic div_init;
        logic div_step;
        logic emit;
        logic [IDX_BITS-1:0] idx;
    } t_iqr_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic [CNT_BITS-1:0] count;
    } t_iqr_sts;

endpackage

>>> hdl/iqr_ctrl.sv
`timescale 1ns / 1ps
module iqr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  iqr_pkg::t_in_item   i_item,
    input  iqr_pkg::t_iqr_sts   i_sts,
    output logic                o_busy,
    output iqr_pkg::t_iqr_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_Q1   = 3'd1;
    localparam logic [2:0] S_Q3   = 3'd2;
    localparam logic [2:0] S_FEN  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int DIV_STEPS = iqr_pkg::NUM_BITS;

    logic [2:0]                  r_state, n_state;
    logic [iqr_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic [iqr_pkg::CNT_BITS-1:0] w_n, w_i1, w_i3, w_np1;
    logic [iqr_pkg::CNT_BITS+1:0] w_i3w;

    // Quartile positions, clamped to the last stored sample.
    always_comb begin
        w_n   = i_sts.count;
        w_np1 = w_n + 1'b1;
        w_i1  = {2'b00, w_np1[iqr_pkg::CNT_BITS-1:2]};
        w_i3w = ({2'b00, w_np1} + {1'b0, w_np1, 1'b0}) >> 2;
        w_i3  = w_i3w[iqr_pkg::CNT_BITS-1:0];
        if (w_i3 > w_n - 1'b1) begin
            w_i3 = w_n - 1'b1;
        end
        if (w_i1 > w_n - 1'b1) begin
            w_i1 = w_n - 1'b1;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_item.last) begin
                    n_state = S_Q1;
                end
            end
            S_Q1: begin
                o_cmd.q1_load = 1'b1;
                o_cmd.idx     = w_i1[iqr_pkg::IDX_BITS-1:0];
                n_state       = S_Q3;
            end
            S_Q3: begin
                o_cmd.q3_load = 1'b1;
                o_cmd.idx     = w_i3[iqr_pkg::IDX_BITS-1:0];
                n_state       = S_FEN;
            end
            S_FEN: begin
                o_cmd.fences = 1'b1;
                n_cnt        = '0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                o_cmd.idx  = r_cnt[iqr_pkg::IDX_BITS-1:0];
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == w_n - 1'b1) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                // While the count is zero, the last scanned sample reaches the sum.
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == iqr_pkg::CNT_BITS'(1)) begin
                    o_cmd.div_init = 1'b1;
                end else if (r_cnt != '0) begin
                    o_cmd.div_step = 1'b1;
                    if (r_cnt == iqr_pkg::CNT_BITS'(DIV_STEPS + 1)) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> hdl/iqr_datapath.sv
`timescale 1ns / 1ps
module iqr_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  iqr_pkg::t_in_item              i_item,
    input  logic [iqr_pkg::FENCE_BITS-1:0] i_fence,
    input  iqr_pkg::t_iqr_cmd              i_cmd,
    output iqr_pkg::t_iqr_sts              o_sts,
    output logic                           o_valid,
    output iqr_pkg::t_out_item             o_item
);

    localparam int SB = iqr_pkg::SAMPLE_BITS;
    localparam int MS = iqr_pkg::MAX_SAMPLES;
    localparam int FB = iqr_pkg::FV_BITS;

    // Insertion-sorting cell chain.
    logic [SB-1:0]                r_cell [MS];
    logic [iqr_pkg::CNT_BITS-1:0] r_fill;
    logic [SB-1:0]                r_q1, r_q3, r_rd;
    logic signed [FB-1:0]         r_hi, r_lo;
    logic [iqr_pkg::SUM_BITS-1:0] r_sum;
    logic [iqr_pkg::CNT_BITS-1:0] r_kept;
    logic [iqr_pkg::NUM_BITS-1:0] r_quot;
    logic [iqr_pkg::CNT_BITS:0]   r_rem;
    logic                         r_valid;
    logic                         r_scan_d;
    logic                         w_full;
    logic [MS-1:0]                w_gt;
    logic signed [FB-1:0]         w_v16, w_iqrf;
    logic [iqr_pkg::CNT_BITS:0]   w_trial;
    logic [iqr_pkg::NUM_BITS-1:0] w_num;

    assign w_full = (r_fill == iqr_pkg::CNT_BITS'(MS));

    // Each cell compares its value with the new sample; cells past fill are empty.
    always_comb begin
        for (int k = 0; k < MS; k++) begin
            w_gt[k] = (r_fill <= iqr_pkg::CNT_BITS'(k)) || (r_cell[k] > i_item.sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            for (int k = 0; k < MS; k++) begin
                if (w_gt[k]) begin
                    if (k == 0 || !w_gt[(k == 0) ? 0 : k-1]) begin
                        r_cell[k] <= i_item.sample;
                    end else begin
                        r_cell[k] <= r_cell[(k == 0) ? 0 : k-1];
                    end
                end
            end
        end
    end

    // Fill count, cleared once the result is sent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load && !w_full) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.emit) begin
            r_fill <= '0;
        end
    end

    // Registered read of one cell at the commanded position.
    always_ff @(posedge i_clk) begin
        r_rd <= r_cell[i_cmd.idx];
    end

    assign w_iqrf = FB'($signed({1'b0, i_fence})) * FB'($signed({1'b0, r_q3 - r_q1}));
    assign w_v16  = FB'($signed({1'b0, r_rd, 4'b0000}));

    // Quartiles and fences.
    always_ff @(posedge i_clk) begin
        if (i_cmd.q1_load) begin
            r_q1 <= r_cell[i_cmd.idx];
        end
        if (i_cmd.q3_load) begin
            r_q3 <= r_cell[i_cmd.idx];
        end
        if (i_cmd.fences) begin
            r_hi <= FB'($signed({1'b0, r_q3, 4'b0000})) + w_iqrf;
            r_lo <= FB'($signed({1'b0, r_q1, 4'b0000})) - w_iqrf;
        end
    end

    // The scan flag is registered so that it lines up with the registered read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_d <= 1'b0;
        end else begin
            r_scan_d <= i_cmd.scan;
        end
    end

    // Kept sum and count, cleared when the fences are set.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fences) begin
            r_sum  <= '0;
            r_kept <= '0;
        end else if (r_scan_d && !(w_v16 > r_hi || w_v16 < r_lo)) begin
            r_sum  <= r_sum + iqr_pkg::SUM_BITS'(r_rd);
            r_kept <= r_kept + 1'b1;
        end
    end

    // Restoring divider, one quotient bit per cycle.
    assign w_num   = {r_sum, 8'h00};
    assign w_trial = {r_rem[iqr_pkg::CNT_BITS-1:0], r_quot[iqr_pkg::NUM_BITS-1]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quot <= w_num;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, r_kept}) begin
                r_rem  <= w_trial - {1'b0, r_kept};
                r_quot <= {r_quot[iqr_pkg::NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_quot <= {r_quot[iqr_pkg::NUM_BITS-2:0], 1'b0};
            end
        end
    end

    // Result register, loaded on emit and held until the next emit; the valid flag is registered from emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_item.mean_q8        <= (r_kept == '0) ? '0 : r_quot[iqr_pkg::MEAN_BITS-1:0];
            o_item.kept_count     <= r_kept;
            o_item.lower_quartile <= r_q1;
            o_item.upper_quartile <= r_q3;
        end
    end

    assign o_valid     = r_valid;
    assign o_sts.count = r_fill;

endmodule

>>> hdl/iqr_trimmed_mean.sv
`timescale 1ns / 1ps
// Interquartile-range trimmed mean. Samples are taken one per cycle while
// busy is low and are sorted on entry by a chain of comparing cells; samples
// beyond 64 in a set are ignored. The sample marked last ends the set: the block
// then stays busy through two quartile reads, fence set-up, a scan of the stored
// sorted cells, a settling step, a divider load, 31 bit-serial divider steps
// and the output step, and raises o_valid for exactly one cycle with the
// result. The receiver cannot stall the result, so it must take the transfer in
// that cycle.
module iqr_trimmed_mean (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  iqr_pkg::t_in_item   i_in,
    output logic                o_valid,
    output iqr_pkg::t_out_item  o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    iqr_pkg::t_iqr_cmd              w_cmd;
    iqr_pkg::t_iqr_sts              w_sts;
    logic [iqr_pkg::FENCE_BITS-1:0] r_fence;
    logic                           w_busy;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fence <= iqr_pkg::FENCE_BITS'(24);
        end else if (psel && penable && pwrite
                     && paddr[1:2-1] == 1'(iqr_pkg::REG_FENCE)) begin
            r_fence <= pwdata[iqr_pkg::FENCE_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[1] == 1'(iqr_pkg::REG_FENCE)) ? {24'h0, r_fence} : 32'h0;
    assign busy   = w_busy;

    iqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_in),
        .i_sts   (w_sts),
        .o_busy  (w_busy),
        .o_cmd   (w_cmd)
    );

    iqr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in),
        .i_fence (r_fence),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_valid (o_valid),
        .o_item  (o_out)
    );

endmodule

>>> hdl/iqr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module iqr_assertions (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_busy,
    input iqr_pkg::t_in_item  i_in,
    input logic               i_valid,
    input iqr_pkg::t_out_item i_out
);

    // A marked transfer makes the block busy.
    `ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_start && !i_busy && i_in.last, i_busy)
    // A result strobe lasts one cycle.
    `ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, i_valid, !i_valid)
    // The block is idle once a result is shown.
    `ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, i_valid, !i_busy)
    // No set of up to 64 samples keeps more.
    `ASSERT_IMP(a_kept_max, i_clk, i_rst_n, i_valid, i_out.kept_count <= 11'd64)

endmodule

bind iqr_trimmed_mean iqr_assertions u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_in    (i_in),
    .i_valid (o_valid),
    .i_out   (o_out)
);
